// ===== rtl/lqs_pkg.sv =====
package lqs_pkg;

    localparam int MaxProcsDefault = 16;
    localparam int DataW = 112;
    localparam int OutW = 120;

    // Register indexes of the configuration channel.
    localparam logic RegQuantum = 1'b0;
    localparam logic RegCount   = 1'b1;

    // Result event codes.
    typedef enum logic [2:0] {
        EV_LOADED   = 3'd0,
        EV_WASTED   = 3'd1,
        EV_ENTERED  = 3'd2,
        EV_TICK     = 3'd3,
        EV_EXPIRED  = 3'd4,
        EV_DONE     = 3'd5,
        EV_ALL_DONE = 3'd6
    } t_event;

endpackage

// ===== rtl/lottery_quantum_scheduler.sv =====
// Sequence: a load or a process-count write stores, then scans every table slot through S_SCAN,
// S_WALKRD and S_FIN for totals. A tick passes S_TICK and S_TICK2; a draw runs a 16-step
// restoring remainder in S_MOD, then a walk over the ticket ranges; a draw with no tickets or
// a step after completion answers straight from S_IDLE.
// Throughput: one item is in flight at a time; the result waits in an output register.
// Reset (synchronous, active low) clears control, tickets and done counts.
module lottery_quantum_scheduler #(
    parameter int MAX_PROCS = lqs_pkg::MaxProcsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: slot[3:0], process_id[19:4], arrival_time[51:20],
    // burst_time[83:52], ticket_count[91:84], random_value[107:92], zeros.
    input  logic [lqs_pkg::DataW-1:0] s_axis_tdata,
    // tuser: operation.
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: event_res[2:0], out_process_id[18:3], time_now[50:19],
    // turnaround[82:51], waiting[114:83], all_finished[115], zeros.
    output logic [lqs_pkg::OutW-1:0] m_axis_tdata
);
    localparam int SW  = $clog2(MAX_PROCS);
    localparam int CW  = $clog2(MAX_PROCS + 1);
    localparam int TW  = 8 + SW + 1;
    localparam int CCW = 5 > CW ? 5 : CW;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_MOD, S_WALK, S_WALKRD, S_CHECK, S_TICK, S_TICK2, S_FIN, S_OUT
    } t_state;

    // Process table memories.
    logic [15:0] r_id_mem  [MAX_PROCS];
    logic [31:0] r_arr_mem [MAX_PROCS];
    logic [31:0] r_bur_mem [MAX_PROCS];
    logic [31:0] r_don_mem [MAX_PROCS];
    logic [7:0]  r_tik_mem [MAX_PROCS];
    logic [MAX_PROCS-1:0] r_vld;

    t_state       r_state;
    logic [15:0]  r_quantum;
    logic [4:0]   r_count;
    logic [TW-1:0] r_total, r_acc;
    logic [CW-1:0] r_fin;
    logic         r_running;
    logic [SW-1:0] r_cur, r_idx;
    logic [15:0]  r_qticks;
    logic [31:0]  r_time;
    logic [15:0]  r_rand;
    logic [TW-1:0] r_rem;
    logic [4:0]   r_bit;
    logic         r_valid;
    logic [lqs_pkg::OutW-1:0] r_out;
    logic [15:0]  r_rd_id;
    logic [31:0]  r_rd_arr, r_rd_bur, r_rd_don;
    logic [7:0]   r_rd_tik;
    logic         r_last;

    logic [CW-1:0] w_used;
    logic          w_all_done;
    logic [TW:0]   w_trial;
    logic [31:0]   w_don_inc, w_tat, w_wt;
    logic [15:0]   w_q_inc;

    assign w_used = (CCW'(r_count) > CCW'(MAX_PROCS)) ? CW'(MAX_PROCS) : CW'(r_count);
    assign w_all_done = r_fin >= w_used;
    assign w_trial = {r_rem, r_rand[15]} - {1'b0, r_total};
    assign w_don_inc = r_rd_don + 32'd1;
    assign w_q_inc = r_qticks + 16'd1;
    assign w_tat = r_time - r_rd_arr;
    assign w_wt = w_tat - r_rd_bur;

    assign o_cfg_ready   = (r_state == S_IDLE) && !r_valid;
    assign s_axis_tready = (r_state == S_IDLE) && !r_valid && !i_cfg_valid;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_out;

    function automatic logic [lqs_pkg::OutW-1:0] pack(
        lqs_pkg::t_event ev, logic [15:0] pid, logic [31:0] t,
        logic [31:0] tat, logic [31:0] wt, logic af);
        return {4'd0, af, wt, tat, t, pid, ev};
    endfunction

    // Table writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready && !s_axis_tuser
            && CCW'(s_axis_tdata[3:0]) < CCW'(MAX_PROCS)) begin
            r_id_mem[SW'(s_axis_tdata[3:0])]  <= s_axis_tdata[19:4];
            r_arr_mem[SW'(s_axis_tdata[3:0])] <= s_axis_tdata[51:20];
            r_bur_mem[SW'(s_axis_tdata[3:0])] <= s_axis_tdata[83:52];
            r_don_mem[SW'(s_axis_tdata[3:0])] <= '0;
            r_tik_mem[SW'(s_axis_tdata[3:0])] <= s_axis_tdata[91:84];
        end else if (r_state == S_TICK2) begin
            r_don_mem[r_idx] <= w_don_inc;
        end
        r_rd_id  <= r_id_mem[r_idx];
        r_rd_arr <= r_arr_mem[r_idx];
        r_rd_bur <= r_bur_mem[r_idx];
        r_rd_don <= r_vld[r_idx] ? r_don_mem[r_idx] : '0;
        r_rd_tik <= r_vld[r_idx] ? r_tik_mem[r_idx] : '0;
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_quantum <= 16'd4; r_count <= 5'd1;
            r_total <= '0; r_fin <= '0; r_running <= 1'b0; r_cur <= '0;
            r_qticks <= '0; r_time <= '0; r_valid <= 1'b0; r_vld <= '0;
            r_idx <= '0; r_last <= 1'b0;
        end else begin
            if (r_valid && m_axis_tready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        if (i_cfg_index == lqs_pkg::RegQuantum) begin
                            r_quantum <= i_cfg_data;
                        end else begin
                            r_count <= i_cfg_data[4:0];
                            if (r_running && CCW'(r_cur) >=
                                ((CCW'(i_cfg_data[4:0]) > CCW'(MAX_PROCS)) ? CCW'(MAX_PROCS)
                                : CCW'(i_cfg_data[4:0]))) begin
                                r_running <= 1'b0; r_qticks <= '0;
                            end
                            r_total <= '0; r_fin <= '0; r_idx <= '0; r_last <= 1'b1;
                            r_state <= S_SCAN;
                        end
                    end else if (s_axis_tvalid && s_axis_tready) begin
                        r_rand <= s_axis_tdata[107:92];
                        r_last <= 1'b0;
                        if (!s_axis_tuser) begin
                            if (CCW'(s_axis_tdata[3:0]) < CCW'(MAX_PROCS)) begin
                                r_vld[SW'(s_axis_tdata[3:0])] <= 1'b1;
                                if (r_running && CCW'(r_cur) == CCW'(s_axis_tdata[3:0])) begin
                                    r_running <= 1'b0; r_qticks <= '0;
                                end
                            end
                            r_out <= pack(lqs_pkg::EV_LOADED, s_axis_tdata[19:4],
                                          r_time, '0, '0, 1'b0);
                            r_total <= '0; r_fin <= '0; r_idx <= '0;
                            r_state <= S_SCAN;
                        end else if (w_all_done) begin
                            r_out <= pack(lqs_pkg::EV_ALL_DONE, '0, r_time, '0, '0, 1'b1);
                            r_valid <= 1'b1;
                        end else if (!r_running) begin
                            if (r_total == '0) begin
                                r_out <= pack(lqs_pkg::EV_WASTED, '0, r_time, '0, '0, 1'b0);
                                r_valid <= 1'b1;
                            end else begin
                                r_rem <= '0; r_bit <= '0; r_state <= S_MOD;
                            end
                        end else begin
                            r_idx <= r_cur; r_state <= S_TICK;
                        end
                    end
                end
                // Wait through S_SCAN and S_WALKRD for the registered read, then accumulate one slot in S_FIN.
                S_SCAN: begin
                    r_state <= S_WALKRD;
                    r_bit <= 5'd1;
                end
                S_WALKRD: begin
                    // r_bit marks scan mode (1) versus draw walk (0).
                    r_state <= r_bit[0] ? S_FIN : S_WALK;
                end
                S_FIN: begin
                    if (CCW'(r_idx) < CCW'(w_used)) begin
                        r_total <= r_total + TW'(r_rd_tik);
                        if (r_rd_don == r_rd_bur) r_fin <= r_fin + CW'(1);
                    end
                    if (CW'(r_idx) == CW'(MAX_PROCS - 1)) begin
                        r_idx <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= r_idx + SW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_OUT: begin
                    if (!r_last) begin
                        r_out[115] <= w_all_done;
                        r_valid <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                // Restoring remainder, one bit of the draw each cycle.
                S_MOD: begin
                    if (!w_trial[TW]) r_rem <= w_trial[TW-1:0];
                    else r_rem <= {r_rem[TW-2:0], r_rand[15]};
                    r_rand <= {r_rand[14:0], 1'b0};
                    if (r_bit == 5'd15) begin
                        r_idx <= '0; r_acc <= '0; r_state <= S_WALKRD;
                        r_bit <= 5'd0;
                    end else begin
                        r_bit <= r_bit + 5'd1;
                    end
                end
                S_WALK: begin
                    if (r_rem < r_acc + TW'(r_rd_tik)) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_acc <= r_acc + TW'(r_rd_tik);
                        r_idx <= r_idx + SW'(1);
                        r_state <= S_WALKRD;
                    end
                end
                S_CHECK: begin
                    if (r_rd_don != r_rd_bur) begin
                        r_running <= 1'b1; r_cur <= r_idx; r_qticks <= '0;
                        r_out <= pack(lqs_pkg::EV_ENTERED, r_rd_id, r_time, '0, '0, 1'b0);
                    end else begin
                        r_out <= pack(lqs_pkg::EV_WASTED, r_rd_id, r_time, '0, '0, 1'b0);
                    end
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_TICK: begin
                    r_time <= r_time + 32'd1;
                    r_state <= S_TICK2;
                end
                S_TICK2: begin
                    if (w_don_inc == r_rd_bur) begin
                        r_fin <= r_fin + CW'(1);
                        r_running <= 1'b0; r_qticks <= '0;
                        r_out <= pack(lqs_pkg::EV_DONE, r_rd_id, r_time, w_tat, w_wt,
                                      (r_fin + CW'(1)) >= w_used);
                    end else if (w_q_inc == r_quantum) begin
                        r_running <= 1'b0; r_qticks <= '0;
                        r_out <= pack(lqs_pkg::EV_EXPIRED, r_rd_id, r_time, '0, '0, 1'b0);
                    end else begin
                        r_qticks <= w_q_inc;
                        r_out <= pack(lqs_pkg::EV_TICK, r_rd_id, r_time, '0, '0, 1'b0);
                    end
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_fin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_fin <= CW'(MAX_PROCS))) else $error("finished overflow");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !m_axis_tready) |=> (r_valid && $stable(r_out)))
        else $error("result dropped");
endmodule

// ===== sim/testbench.sv =====
module testbench;

    localparam int NumSlots = 16;
    localparam int SettleCycles = 60;
    localparam int StallLimit = 5000;

    // One input item of the scheduler, unpacked.
    typedef struct {
        logic        op;
        logic [3:0]  slot;
        logic [15:0] pid;
        logic [31:0] arrival;
        logic [31:0] burst;
        logic [7:0]  tickets;
        logic [15:0] draw;
    } t_sched_item;

    // One scheduling event as reported by the block.
    typedef struct {
        lqs_pkg::t_event ev;
        logic [15:0] pid;
        logic [31:0] now;
        logic [31:0] turnaround;
        logic [31:0] waiting;
        logic        all_done;
    } t_sched_event;

    // Scheduler twin: keeps its own process table and the events still owed.
    class sched_scoreboard;
        logic [15:0] ids [NumSlots];
        logic [31:0] arrivals [NumSlots];
        logic [31:0] bursts [NumSlots];
        logic [7:0]  tickets [NumSlots];
        logic [31:0] done_ticks [NumSlots];
        int          ticket_sum;
        int          finished;
        bit          busy;
        int          cur;
        logic [15:0] quantum_ticks;
        logic [31:0] clock_now;
        logic [15:0] quantum;
        logic [4:0]  count;
        t_sched_event pending_events [$];
        int          mismatches;

        function new();
            foreach (ids[i]) begin
                ids[i] = '0;
                arrivals[i] = '0;
                bursts[i] = '0;
                tickets[i] = '0;
                done_ticks[i] = '0;
            end
            busy = 0;
            cur = 0;
            quantum_ticks = '0;
            clock_now = '0;
            quantum = 16'd4;
            count = 5'd1;
            mismatches = 0;
            retally();
        endfunction

        function int live_slots();
            return (count > NumSlots) ? NumSlots : int'(count);
        endfunction

        // Recount the ticket pool and the finished processes over the slots in use.
        function void retally();
            ticket_sum = 0;
            finished = 0;
            for (int s = 0; s < live_slots(); s++) begin
                ticket_sum += tickets[s];
                if (done_ticks[s] == bursts[s]) finished++;
            end
        endfunction

        function void set_reg(logic idx, logic [15:0] value);
            if (idx == lqs_pkg::RegQuantum) begin
                quantum = value;
            end else begin
                count = value[4:0];
                if (busy && cur >= live_slots()) begin
                    busy = 0;
                    quantum_ticks = '0;
                end
                retally();
            end
        endfunction

        // Advance the scheduler by one accepted item and queue the event it owes.
        function void note_item(t_sched_item it);
            t_sched_event e;
            int           r;
            int           acc;
            int           owner;
            e.ev = lqs_pkg::EV_LOADED;
            e.pid = '0;
            e.turnaround = '0;
            e.waiting = '0;
            if (it.op == 1'b0) begin
                ids[it.slot] = it.pid;
                arrivals[it.slot] = it.arrival;
                bursts[it.slot] = it.burst;
                tickets[it.slot] = it.tickets;
                done_ticks[it.slot] = '0;
                if (busy && cur == it.slot) begin
                    busy = 0;
                    quantum_ticks = '0;
                end
                retally();
                e.pid = it.pid;
            end else if (finished >= live_slots()) begin
                e.ev = lqs_pkg::EV_ALL_DONE;
            end else if (!busy) begin
                e.ev = lqs_pkg::EV_WASTED;
                if (ticket_sum != 0) begin
                    r = int'(it.draw) % ticket_sum;
                    acc = 0;
                    owner = 0;
                    for (int s = 0; s < live_slots(); s++) begin
                        acc += tickets[s];
                        if (r < acc) begin
                            owner = s;
                            break;
                        end
                    end
                    e.pid = ids[owner];
                    if (done_ticks[owner] != bursts[owner]) begin
                        busy = 1;
                        cur = owner;
                        quantum_ticks = '0;
                        e.ev = lqs_pkg::EV_ENTERED;
                    end
                end
            end else begin
                e.pid = ids[cur];
                clock_now = clock_now + 32'd1;
                done_ticks[cur] = done_ticks[cur] + 32'd1;
                quantum_ticks = quantum_ticks + 16'd1;
                if (done_ticks[cur] == bursts[cur]) begin
                    e.turnaround = clock_now - arrivals[cur];
                    e.waiting = e.turnaround - bursts[cur];
                    finished++;
                    busy = 0;
                    quantum_ticks = '0;
                    e.ev = lqs_pkg::EV_DONE;
                end else if (quantum_ticks == quantum) begin
                    busy = 0;
                    quantum_ticks = '0;
                    e.ev = lqs_pkg::EV_EXPIRED;
                end else begin
                    e.ev = lqs_pkg::EV_TICK;
                end
            end
            e.now = clock_now;
            e.all_done = (finished >= live_slots());
            pending_events.push_back(e);
        endfunction

        function void check_event(t_sched_event got);
            t_sched_event want;
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event %0d pid %h", got.ev, got.pid);
                return;
            end
            want = pending_events.pop_front();
            if (got.ev !== want.ev || got.pid !== want.pid || got.now !== want.now ||
                got.turnaround !== want.turnaround || got.waiting !== want.waiting ||
                got.all_done !== want.all_done) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("event mismatch: want ev %0d pid %h t %h tat %h wt %h all %b, ",
                             want.ev, want.pid, want.now, want.turnaround, want.waiting,
                             want.all_done,
                             "got ev %0d pid %h t %h tat %h wt %h all %b",
                             got.ev, got.pid, got.now, got.turnaround,
                             got.waiting, got.all_done);
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic         i_cfg_index = lqs_pkg::RegQuantum;
    logic [15:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [lqs_pkg::DataW-1:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [lqs_pkg::OutW-1:0] m_axis_tdata;

    sched_scoreboard sb = new();
    int tx_idle_pct = 17;
    int rx_idle_pct = 78;
    int quiet_cycles = 0;
    bit any_transfer;

    lottery_quantum_scheduler u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Result side: random back-pressure and a check of every event transfer.
    always @(posedge i_clk) begin
        t_sched_event got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.ev = lqs_pkg::t_event'(m_axis_tdata[2:0]);
                got.pid = m_axis_tdata[18:3];
                got.now = m_axis_tdata[50:19];
                got.turnaround = m_axis_tdata[82:51];
                got.waiting = m_axis_tdata[114:83];
                got.all_done = m_axis_tdata[115];
                sb.check_event(got);
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        any_transfer = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                       (i_cfg_valid && o_cfg_ready);
        quiet_cycles = any_transfer ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present one item, possibly after a random gap, and wait for its transfer.
    task automatic send_item(t_sched_item it);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.op;
        s_axis_tdata <= {4'b0, it.draw, it.tickets, it.burst, it.arrival, it.pid, it.slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_item(it);
    endtask

    // Stop sending and wait until every owed event has arrived.
    task automatic drain(int settle);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_events.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load(logic [3:0] slot, logic [15:0] pid, logic [31:0] arrival,
                        logic [31:0] burst, logic [7:0] tix);
        t_sched_item it;
        it = '{1'b0, slot, pid, arrival, burst, tix, 16'($urandom)};
        send_item(it);
    endtask

    task automatic step(logic [15:0] draw);
        t_sched_item it;
        it = '{1'b1, 4'($urandom), 16'($urandom), $urandom, $urandom, 8'($urandom), draw};
        send_item(it);
    endtask

    // Random load with mostly short bursts so processes actually finish.
    task automatic random_load();
        logic [31:0] burst;
        logic [7:0]  tix;
        case ($urandom_range(31))
            0: burst = '0;
            1, 2: burst = $urandom;
            default: burst = $urandom_range(6, 1);
        endcase
        tix = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom);
        load(4'($urandom), 16'($urandom), $urandom, burst, tix);
    endtask

    initial begin
        logic [15:0] qlen;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every slot is loaded up front, so no slot in use is ever read unwritten.
        for (int s = 0; s < NumSlots; s++)
            load(4'(s), 16'(s * 16'h1111), 32'(s), 32'(s % 3 + 1), 8'(s * 17));
        step(16'h0000);
        step(16'hFFFF);
        load(4'd15, 16'hFFFF, 32'hFFFF_FFFF, 32'd2, 8'hFF);
        load(4'd3, 16'h0003, 32'd0, 32'd0, 8'd5);
        drain(SettleCycles);
        write_reg(lqs_pkg::RegQuantum, 16'd2);
        write_reg(lqs_pkg::RegCount, 16'd4);
        for (int i = 0; i < 6; i++) step(16'($urandom));
        drain(SettleCycles);
        write_reg(lqs_pkg::RegCount, 16'd0);
        step(16'd7);
        drain(SettleCycles);
        write_reg(lqs_pkg::RegCount, 16'd20);
        write_reg(lqs_pkg::RegQuantum, 16'd0);
        step(16'd9);
        step(16'd9);

        // Random phases under three idling patterns.
        for (int ph = 0; ph < 12; ph++) begin
            tx_idle_pct = (ph < 4) ? 17 : (ph < 8) ? 78 : 0;
            rx_idle_pct = (ph < 4) ? 78 : (ph < 8) ? 17 : 0;
            drain(SettleCycles);
            case ($urandom_range(4))
                0: qlen = 16'd1;
                1: qlen = 16'hFFFF;
                2: qlen = 16'd2;
                default: qlen = 16'($urandom_range(8, 1));
            endcase
            if (ph == 0) qlen = 16'd1;
            if (ph == 1) qlen = 16'hFFFF;
            write_reg(lqs_pkg::RegQuantum, qlen);
            write_reg(lqs_pkg::RegCount, (ph == 2) ? 16'd16 : (ph == 3) ? 16'd1 :
                      16'($urandom_range(16, 1)) | (16'($urandom) & 16'hFFE0));
            for (int i = 0; i < 95; i++) begin
                if (ph == 5 && i == 40) drain(0);
                if ($urandom_range(3) == 0) random_load();
                else step(16'($urandom));
            end
        end

        drain(SettleCycles);
        if (sb.mismatches == 0 && sb.pending_events.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/lqs_pkg.sv
rtl/lottery_quantum_scheduler.sv
sim/testbench.sv
